// ===== sv/normal_map_pixel_encoder_core_macros.svh =====
// Assertion macros used by the checker of the normal map pixel encoder.
// Depends on nothing; users must provide clk_i and rst_ni in scope.
`ifndef NORMAL_MAP_PIXEL_ENCODER_CORE_MACROS_SVH
`define NORMAL_MAP_PIXEL_ENCODER_CORE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define NMPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define NMPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/nmpe_pkg.sv =====
// Shared constants and types of the normal map pixel encoder.
// Used by the core and by its checker; depends on nothing.
package nmpe_pkg;

  typedef logic [7:0] code_t;

  localparam int NUM_LANES    = 3;
  localparam int LANE_Y       = 0;
  localparam int LANE_X       = 1;
  localparam int LANE_Z       = 2;
  localparam int SEARCH_STEPS = 8;
  localparam int ASQ_W        = 16;
  localparam int PIPE_LAT     = 28;

  localparam code_t CENTER_CODE = 8'd127;
  localparam code_t FULL_CODE   = 8'd255;
  localparam code_t ZERO_CODE   = 8'd0;

endpackage

// ===== sv/normal_map_pixel_encoder_core.sv =====
// Normal map pixel encoder core: normalizes (unit Z + high - base) and packs it to RGB8.
// Depends on nmpe_pkg.
// Throughput: one item per cycle; busy_o stays low, so start_i is taken every cycle.
// The result passes the three front stages, then the 8-step bit-serial channel search, three register
// stages per step (trial square, split multiply, combine and compare), then one output stage.
// Reset clears the valid bits only; payload registers are not reset.
module normal_map_pixel_encoder_core
  import nmpe_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] high_nx_i,
  input  logic signed [15:0] high_ny_i,
  input  logic signed [15:0] high_nz_i,
  input  logic signed [15:0] base_nx_i,
  input  logic signed [15:0] base_ny_i,
  input  logic signed [15:0] base_nz_i,
  output logic               valid_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  localparam int VW  = (FRAC_BITS > 16) ? FRAC_BITS + 2 : 18;
  localparam int MW  = VW - 1;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int SLO = SW / 2;
  localparam int SHI = SW - SLO;
  localparam int PW  = SW + ASQ_W;
  localparam int PLW = SLO + ASQ_W;
  localparam int PHW = SHI + ASQ_W;

  localparam logic signed [VW-1:0] ONE_Q = VW'(1) << FRAC_BITS;

  typedef struct packed {
    code_t            k;
    logic             neg;
    logic [PW-1:0]    bsq;
    logic [ASQ_W-1:0] asq;
    logic [PLW-1:0]   pp_lo;
    logic [PHW-1:0]   pp_hi;
  } lane_t;

  typedef struct packed {
    logic                         zero;
    logic [SW-1:0]                s;
    lane_t [NUM_LANES-1:0]        lane;
  } srch_t;

  function automatic logic [ASQ_W-1:0] trial_sq(code_t t, logic centred);
    code_t m;
    begin
      if (centred) begin
        m = t[7] ? {t[6:0], 1'b1} : {~t[6:0], 1'b1};
      end else begin
        m = t;
      end
      return ASQ_W'(m) * ASQ_W'(m);
    end
  endfunction

  logic in_acc;
  assign in_acc = start_i & ~busy_o;
  assign busy_o = 1'b0;

  logic                           v1_q;
  logic [NUM_LANES-1:0][MW-1:0]   mag_d, mag1_q;
  logic [NUM_LANES-1:0]           neg_d, neg1_q;

  always_comb begin
    logic signed [VW-1:0] v [NUM_LANES];
    v[LANE_X] = VW'(high_nx_i) - VW'(base_nx_i);
    v[LANE_Y] = VW'(high_ny_i) - VW'(base_ny_i);
    v[LANE_Z] = ONE_Q + VW'(high_nz_i) - VW'(base_nz_i);
    for (int l = 0; l < NUM_LANES; l++) begin
      neg_d[l] = v[l][VW-1];
      mag_d[l] = neg_d[l] ? MW'(-v[l]) : MW'(v[l]);
    end
  end

  logic                           v2_q;
  logic [NUM_LANES-1:0][SQW-1:0]  sq_d, sq2_q;
  logic [NUM_LANES-1:0]           neg2_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      sq_d[l] = SQW'(mag1_q[l]) * SQW'(mag1_q[l]);
    end
  end

  logic  p3_v_q;
  srch_t p3_d, p3_q;

  always_comb begin
    logic [PW-1:0] w;
    p3_d      = '0;
    p3_d.s    = SW'(sq2_q[LANE_X]) + SW'(sq2_q[LANE_Y]) + SW'(sq2_q[LANE_Z]);
    p3_d.zero = (sq2_q[LANE_X] == '0) && (sq2_q[LANE_Y] == '0) && (sq2_q[LANE_Z] == '0);
    for (int l = 0; l < NUM_LANES; l++) begin
      // 255 squared is 2^16 - 2^9 + 1.
      w                = PW'(sq2_q[l]);
      p3_d.lane[l].neg = neg2_q[l];
      p3_d.lane[l].bsq = (w << 16) - (w << 9) + w;
    end
  end

  srch_t                   a_src [SEARCH_STEPS];
  logic [SEARCH_STEPS-1:0] a_src_v;
  srch_t                   a_d [SEARCH_STEPS], a_q [SEARCH_STEPS];
  srch_t                   b_d [SEARCH_STEPS], b_q [SEARCH_STEPS];
  srch_t                   c_d [SEARCH_STEPS], c_q [SEARCH_STEPS];
  logic [SEARCH_STEPS-1:0] a_v_q, b_v_q, c_v_q;

  for (genvar j = 0; j < SEARCH_STEPS; j++) begin : g_step
    localparam code_t TBIT = 8'h80 >> j;

    if (j == 0) begin : g_first
      assign a_src[j]   = p3_q;
      assign a_src_v[j] = p3_v_q;
    end else begin : g_next
      assign a_src[j]   = c_q[j-1];
      assign a_src_v[j] = c_v_q[j-1];
    end

    always_comb begin
      a_d[j] = a_src[j];
      for (int l = 0; l < NUM_LANES; l++) begin
        a_d[j].lane[l].asq = trial_sq(a_src[j].lane[l].k | TBIT, l != LANE_Z);
      end
    end

    always_comb begin
      b_d[j] = a_q[j];
      for (int l = 0; l < NUM_LANES; l++) begin
        b_d[j].lane[l].pp_lo = PLW'(a_q[j].lane[l].asq) * PLW'(a_q[j].s[SLO-1:0]);
        b_d[j].lane[l].pp_hi = PHW'(a_q[j].lane[l].asq) * PHW'(a_q[j].s[SW-1:SLO]);
      end
    end

    always_comb begin
      logic [PW-1:0] lhs;
      code_t         t;
      logic          a_pos;
      logic          take;
      c_d[j] = b_q[j];
      for (int l = 0; l < NUM_LANES; l++) begin
        t     = b_q[j].lane[l].k | TBIT;
        lhs   = {b_q[j].lane[l].pp_hi, {SLO{1'b0}}} + PW'(b_q[j].lane[l].pp_lo);
        a_pos = (l == LANE_Z) ? 1'b1 : t[7];
        if (a_pos) begin
          take = ~b_q[j].lane[l].neg & (lhs <= b_q[j].lane[l].bsq);
        end else begin
          take = ~b_q[j].lane[l].neg | (lhs >= b_q[j].lane[l].bsq);
        end
        if (take) begin
          c_d[j].lane[l].k = t;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      a_q[j] <= a_d[j];
      b_q[j] <= b_d[j];
      c_q[j] <= c_d[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[j] <= 1'b0;
        b_v_q[j] <= 1'b0;
        c_v_q[j] <= 1'b0;
      end else begin
        a_v_q[j] <= a_src_v[j];
        b_v_q[j] <= a_v_q[j];
        c_v_q[j] <= b_v_q[j];
      end
    end
  end

  srch_t last;
  code_t red_d, green_d, blue_d;
  code_t red_q, green_q, blue_q;
  logic  out_v_q;

  assign last    = c_q[SEARCH_STEPS-1];
  assign red_d   = last.zero ? CENTER_CODE : last.lane[LANE_Y].k;
  assign green_d = last.zero ? CENTER_CODE : last.lane[LANE_X].k;
  assign blue_d  = last.zero ? ZERO_CODE   : last.lane[LANE_Z].k;

  always_ff @(posedge clk_i) begin
    mag1_q  <= mag_d;
    neg1_q  <= neg_d;
    sq2_q   <= sq_d;
    neg2_q  <= neg1_q;
    p3_q    <= p3_d;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      p3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q    <= in_acc;
      v2_q    <= v1_q;
      p3_v_q  <= v2_q;
      out_v_q <= c_v_q[SEARCH_STEPS-1];
    end
  end

  assign valid_o = out_v_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ===== sv/nmpe_checker.sv =====
// Port-level checker for the normal map pixel encoder core, with its bind statement.
// Depends on nmpe_pkg and normal_map_pixel_encoder_core_macros.svh.
`include "normal_map_pixel_encoder_core_macros.svh"

module nmpe_checker
  import nmpe_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [15:0] high_nx_i,
  input logic signed [15:0] high_ny_i,
  input logic signed [15:0] high_nz_i,
  input logic signed [15:0] base_nx_i,
  input logic signed [15:0] base_ny_i,
  input logic signed [15:0] base_nz_i,
  input logic               valid_o,
  input logic [7:0]         red_o,
  input logic [7:0]         green_o,
  input logic [7:0]         blue_o
);

  logic acc;
  logic flat_xy;
  logic flat_z;

  assign acc     = start_i && !busy_o;
  assign flat_xy = (high_nx_i == base_nx_i) && (high_ny_i == base_ny_i);
  assign flat_z  = (high_nz_i == base_nz_i);

  // Every accepted item yields exactly one result after the fixed latency.
  `NMPE_ASSERT(a_result_follows, acc |-> ##PIPE_LAT valid_o, "accepted item gave no result")
  `NMPE_ASSERT(a_result_has_item, valid_o |-> $past(acc, PIPE_LAT), "result without an item")

  // A vector with no tangential part encodes to the center of red and green.
  `NMPE_ASSERT(a_flat_xy, acc && flat_xy |-> ##PIPE_LAT (red_o == CENTER_CODE && green_o == CENTER_CODE), "tangential zero not centered")

  // Identical normals give the unit Z vector, which is full blue.
  `NMPE_ASSERT(a_flat_surface, acc && flat_xy && flat_z |-> ##PIPE_LAT (blue_o == FULL_CODE), "unit Z not full blue")

  `NMPE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !valid_o, "result strobe during reset")

endmodule

bind normal_map_pixel_encoder_core nmpe_checker u_nmpe_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of normal_map_pixel_encoder_core: normal pairs in, RGB8 codes out.
// An exact integer predictor computes each item's codes; a monitor checks them in order.
// Depends on nmpe_pkg and the core only.
module tb;
  import nmpe_pkg::*;

  localparam int FRAC_BITS  = 14;
  localparam int IDLE_LIMIT = 2000;
  localparam int PRINT_CAP  = 50;

  typedef struct packed {
    code_t red;
    code_t green;
    code_t blue;
  } pixel_rgb_t;

  typedef struct {
    logic signed [15:0] hx, hy, hz;
    logic signed [15:0] bx, by, bz;
    bit                 drain_first;
  } pixel_in_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               start_i   = 1'b0;
  logic signed [15:0] high_nx_i = '0;
  logic signed [15:0] high_ny_i = '0;
  logic signed [15:0] high_nz_i = '0;
  logic signed [15:0] base_nx_i = '0;
  logic signed [15:0] base_ny_i = '0;
  logic signed [15:0] base_nz_i = '0;
  logic               busy_o;
  logic               valid_o;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;

  pixel_in_t  pixel_queue[$];
  pixel_rgb_t expected_rgb[$];
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  int         gap_left       = 0;
  int         burst_left     = 0;

  normal_map_pixel_encoder_core #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // True when a * sqrt(s) <= b, decided on exact squares.
  function automatic bit scaled_at_most(input longint a, input longint b,
                                        input longint unsigned s);
    longint unsigned mag_a, mag_b;
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    if (a <= 0) return (b >= 0) || (mag_a * mag_a * s >= mag_b * mag_b);
    return (b >= 0) && (mag_a * mag_a * s <= mag_b * mag_b);
  endfunction

  // Bit-serial search for the largest code that the component still reaches.
  function automatic code_t channel_code(input longint c, input longint unsigned s,
                                         input bit centered);
    longint code, trial, lhs;
    code = 0;
    if (!centered && c <= 0) return ZERO_CODE;
    for (int b = SEARCH_STEPS - 1; b >= 0; b--) begin
      trial = code | (longint'(1) << b);
      lhs   = centered ? 2 * trial - longint'(FULL_CODE) : trial;
      if (scaled_at_most(lhs, longint'(FULL_CODE) * c, s)) code = trial;
    end
    return code_t'(code);
  endfunction

  function automatic pixel_rgb_t encode_pixel(
    input logic signed [15:0] hx, hy, hz, bx, by, bz);
    longint          vx, vy, vz;
    longint unsigned len_sq;
    pixel_rgb_t      rgb;
    vx     = longint'(hx) - longint'(bx);
    vy     = longint'(hy) - longint'(by);
    vz     = (longint'(1) << FRAC_BITS) + longint'(hz) - longint'(bz);
    len_sq = vx * vx + vy * vy + vz * vz;
    if (len_sq == 0) begin
      rgb.red   = CENTER_CODE;
      rgb.green = CENTER_CODE;
      rgb.blue  = ZERO_CODE;
    end else begin
      rgb.red   = channel_code(vy, len_sq, 1'b1);
      rgb.green = channel_code(vx, len_sq, 1'b1);
      rgb.blue  = channel_code(vz, len_sq, 1'b0);
    end
    return rgb;
  endfunction

  function automatic logic signed [15:0] rand_q14();
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [15:0] rand_edge();
    case ($urandom_range(0, 6))
      0: return -16'sd32768;
      1: return -16'sd16384;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd16384;
      default: return 16'sd32767;
    endcase
  endfunction

  task automatic queue_pixel(input logic signed [15:0] hx, hy, hz, bx, by, bz,
                             input bit drain);
    pixel_in_t item;
    item = '{hx, hy, hz, bx, by, bz, drain};
    pixel_queue.push_back(item);
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : drive_pixels
    int r;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_rgb.push_back(encode_pixel(high_nx_i, high_ny_i, high_nz_i,
                                            base_nx_i, base_ny_i, base_nz_i));
        pixel_queue.delete(0);
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) burst_left = $urandom_range(30, 120);
          else if (r < 55) gap_left = 0;
          else if (r < 85) gap_left = $urandom_range(1, 3);
          else if (r < 97) gap_left = $urandom_range(4, 12);
          else gap_left = $urandom_range(20, 60);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pixel_queue.size() == 0 ||
                   (pixel_queue[0].drain_first && expected_rgb.size() != 0)) begin
        start_i <= 1'b0;
      end else begin
        start_i   <= 1'b1;
        high_nx_i <= pixel_queue[0].hx;
        high_ny_i <= pixel_queue[0].hy;
        high_nz_i <= pixel_queue[0].hz;
        base_nx_i <= pixel_queue[0].bx;
        base_ny_i <= pixel_queue[0].by;
        base_nz_i <= pixel_queue[0].bz;
      end
    end
  end

  always @(posedge clk_i) begin : check_rgb
    pixel_rgb_t want;
    if (rst_ni && valid_o) begin
      if (expected_rgb.size() == 0) begin
        report_mismatch($sformatf("unexpected item rgb=%0d,%0d,%0d",
                                  red_o, green_o, blue_o));
      end else begin
        want = expected_rgb.pop_front();
        if (red_o !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", red_o, want.red));
        if (green_o !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", green_o, want.green));
        if (blue_o !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", blue_o, want.blue));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rst_ni && start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic signed [15:0] hx, hy, hz, bx, by, bz;
    int                 kind;
    bit                 drain;

    // Directed items: axis vectors, zero-length vectors, negative z and field extremes.
    queue_pixel(0, 0, 0, 0, 0, 0, 1'b0);
    queue_pixel(0, 0, -16384, 0, 0, 0, 1'b0);
    queue_pixel(100, -200, 0, 100, -200, 16384, 1'b0);
    queue_pixel(16384, 0, -16384, 0, 0, 0, 1'b0);
    queue_pixel(-16384, 0, -16384, 0, 0, 0, 1'b0);
    queue_pixel(0, 16384, -16384, 0, 0, 0, 1'b0);
    queue_pixel(0, -16384, -16384, 0, 0, 0, 1'b0);
    queue_pixel(0, 0, -32768, 0, 0, 0, 1'b0);
    queue_pixel(32767, 32767, 32767, -32768, -32768, -32768, 1'b0);
    queue_pixel(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0);
    queue_pixel(-32768, -32768, -32768, 0, 0, 0, 1'b0);
    queue_pixel(0, 0, 0, 32767, 32767, 32767, 1'b0);
    queue_pixel(16384, 16384, 16384, 16384, 16384, 16384, 1'b0);
    queue_pixel(32767, -32768, 0, -32768, 32767, 0, 1'b0);
    queue_pixel(1, 0, -16384, 0, 0, 0, 1'b0);
    queue_pixel(1, 1, -16384, 0, 0, 0, 1'b0);
    queue_pixel(-1, -1, -16384, 0, 0, 0, 1'b0);
    queue_pixel(0, 0, -16383, 0, 0, 0, 1'b0);
    queue_pixel(-16384, -16384, -16384, 16384, 16384, 16384, 1'b0);
    queue_pixel(16384, -16384, 16384, -16384, 16384, -16384, 1'b0);

    for (int i = 0; i < 1000; i++) begin
      drain = (i == 0) || ($urandom_range(0, 249) == 0);
      kind  = $urandom_range(0, 99);
      bx = rand_q14();
      by = rand_q14();
      bz = rand_q14();
      if (kind < 40) begin
        hx = rand_q14();
        hy = rand_q14();
        hz = rand_q14();
      end else if (kind < 70) begin
        hx = bx + 16'(int'($urandom_range(0, 2000)) - 1000);
        hy = by + 16'(int'($urandom_range(0, 2000)) - 1000);
        hz = bz + 16'(int'($urandom_range(0, 2000)) - 1000);
      end else if (kind < 85) begin
        hx = 16'($urandom());
        hy = 16'($urandom());
        hz = 16'($urandom());
        bx = 16'($urandom());
        by = 16'($urandom());
        bz = 16'($urandom());
      end else if (kind < 95) begin
        hx = bx;
        hy = by;
        hz = bz - 16'sd16384;
      end else begin
        hx = rand_edge();
        hy = rand_edge();
        hz = rand_edge();
        bx = rand_edge();
        by = rand_edge();
        bz = rand_edge();
      end
      queue_pixel(hx, hy, hz, bx, by, bz, drain);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_queue.size() != 0 || start_i) @(posedge clk_i);
    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
